@@ rtl/rrrh_pkg.sv @@
// Package with shared constants and types for the residual ratio histogram.
package rrrh_pkg;

  localparam int unsigned SumXBits  = 24;
  localparam int unsigned SumXXBits = 38;
  localparam int unsigned SumXYBits = 39;
  // Variance and covariance terms: n*S2 needs 8+39 bits plus sign headroom.
  localparam int unsigned VarBits   = 64;
  localparam int unsigned ProdBits  = 128;
  localparam int unsigned MulBits   = 32;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam logic KIND_FIT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  // Operation codes of the shared multiply-accumulate unit.
  typedef enum logic [1:0] {
    MAC_LOAD = 2'd0,
    MAC_ADD  = 2'd1,
    MAC_SUB  = 2'd2
  } mac_op_e;

  typedef struct packed {
    logic    start;
    mac_op_e op;
  } mac_ctrl_t;

endpackage

@@ rtl/rrrh_mac.sv @@
// Shared 32x32 multiplier with a 128-bit accumulator, one partial product per cycle.
module rrrh_mac (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rrrh_pkg::mac_ctrl_t              ctrl_i,
  input  logic [rrrh_pkg::MulBits-1:0]     a_i,
  input  logic [rrrh_pkg::MulBits-1:0]     b_i,
  input  logic [6:0]                       shift_i,
  output logic [rrrh_pkg::ProdBits-1:0]    acc_o
);

  logic [2*rrrh_pkg::MulBits-1:0] prod_q;
  logic [rrrh_pkg::ProdBits-1:0]  acc_q, acc_d, term;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign term = {{(rrrh_pkg::ProdBits-2*rrrh_pkg::MulBits){1'b0}}, prod_q} << shift_i;

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.start) begin
      case (ctrl_i.op)
        rrrh_pkg::MAC_LOAD: acc_d = term;
        rrrh_pkg::MAC_ADD:  acc_d = acc_q + term;
        rrrh_pkg::MAC_SUB:  acc_d = acc_q - term;
        default:            acc_d = acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/regression_residual_ratio_histogram.sv @@
// Top level: sample accumulation, fit sequencer, divider and histogram memory.
//
// A sample pair is accepted and its sums and products are accumulated on a small 16x16
// multiplier before another pair is taken; once the sample limit is reached a pair is
// passed over without being accumulated. The pair marked last then starts the fit: the
// variance and covariance terms and then the two 128-bit products are formed on one shared
// 32x32 multiplier, and the bin then comes from a restoring divider, one quotient bit per
// cycle over (log2 HIST_BINS + 6) quotient bits, followed by a read-modify-write of the
// histogram memory. When y has zero variance the fit skips the products, divider and
// memory; when x has zero variance it skips the products and divider. A read request reads
// its bin through the registered read port. A result waits in an output register and
// the block keeps accepting items until the next result is ready behind it. After reset a
// clearing pass writes every bin once, and no item is accepted meanwhile.
module regression_residual_ratio_histogram #(
  parameter int unsigned HIST_BINS   = 65536,
  parameter int unsigned MAX_SAMPLES = 128,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        req_type_i,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] y_value_i,
  input  logic        last_sample_i,
  input  logic [15:0] bin_address_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        result_kind_o,
  output logic [15:0] bin_index_o,
  output logic [31:0] bin_count_o,
  output logic        zero_variance_o
);

  localparam int unsigned AddrBits = $clog2(HIST_BINS);
  localparam int unsigned QBits    = AddrBits + 6;
  localparam int unsigned VB       = rrrh_pkg::VarBits;
  localparam int unsigned PB       = rrrh_pkg::ProdBits;
  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [QBits-1:0]      BinMax   = QBits'(HIST_BINS - 1);

  localparam logic [4:0] S_CLEAR = 5'd0,  S_IDLE = 5'd1,  S_ACC = 5'd2,
                         S_MUL   = 5'd3,  S_MWAIT = 5'd4, S_VAR = 5'd5,
                         S_ABS   = 5'd6,  S_PMUL = 5'd7,  S_PWAIT = 5'd8,
                         S_PNEXT = 5'd9,  S_NUM  = 5'd10, S_DIV = 5'd11,
                         S_RD    = 5'd12, S_RDW  = 5'd13, S_WR = 5'd14,
                         S_RRD   = 5'd15, S_RRW  = 5'd16, S_OUT = 5'd17;

  logic [4:0] state_q, state_d;

  // Sums.
  logic [7:0]                              n_q;
  logic signed [rrrh_pkg::SumXBits-1:0]    sx_q, sy_q;
  logic signed [rrrh_pkg::SumXXBits-1:0]   sxx_q, syy_q;
  logic signed [rrrh_pkg::SumXYBits-1:0]   sxy_q;
  logic signed [15:0]                      x_q, y_q;
  logic                                    last_q, take_q;

  // Products of the sample step (one multiplier, registered).
  logic signed [31:0] sq_q;
  logic [1:0]         sub_q;

  // Fit sequencing.
  logic [2:0]  term_q;     // 0: vx, 1: vy, 2: c
  logic        half_q;     // 0: n*S2, 1: -S*S
  logic signed [VB-1:0] vx_q, vy_q, c_q, t_q;
  logic [VB-1:0] pa_q, pb_q;
  logic [1:0]  part_q;
  logic        pidx_q;     // 0: den, 1: c^2
  logic [PB-1:0] den_q;
  logic [PB+AddrBits-1:0] rem_q;
  logic [QBits-1:0] q_q;
  logic [6:0]  cnt_q;

  // Histogram memory.
  logic [COUNT_BITS-1:0] mem [HIST_BINS];
  logic [COUNT_BITS-1:0] rd_q;
  logic [AddrBits-1:0]   addr_q;
  logic [AddrBits:0]     clr_q;
  logic                  oor_q;

  // Working result and output register.
  logic        ov_q, kind_q, zv_q;
  logic [15:0] idx_q;
  logic [31:0] cnt_out_q;
  logic        res_kind_q, res_zv_q;
  logic [15:0] res_idx_q;
  logic [31:0] res_cnt_q;

  // Shared multiplier.
  rrrh_pkg::mac_ctrl_t   mctl;
  logic [31:0]           ma, mb;
  logic [6:0]            msh;
  logic [PB-1:0]         macc;

  rrrh_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mctl),
    .a_i    (ma),
    .b_i    (mb),
    .shift_i(msh),
    .acc_o  (macc)
  );

  logic accept, out_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = (state_q == S_OUT) && (!ov_q || out_ready_i);

  // Operand selection for the variance terms: signed values made magnitude plus sign.
  logic signed [VB-1:0] opa_s, opb_s;
  logic                 neg;
  logic [VB-1:0]        absa, absb;
  always_comb begin
    opa_s = '0;
    opb_s = '0;
    case (term_q)
      3'd0: begin
        opa_s = half_q ? VB'(sx_q) : VB'({1'b0, n_q});
        opb_s = half_q ? VB'(sx_q) : VB'(sxx_q);
      end
      3'd1: begin
        opa_s = half_q ? VB'(sy_q) : VB'({1'b0, n_q});
        opb_s = half_q ? VB'(sy_q) : VB'(syy_q);
      end
      default: begin
        opa_s = half_q ? VB'(sx_q) : VB'({1'b0, n_q});
        opb_s = half_q ? VB'(sy_q) : VB'(sxy_q);
      end
    endcase
    absa = opa_s[VB-1] ? VB'(-opa_s) : VB'(opa_s);
    absb = opb_s[VB-1] ? VB'(-opb_s) : VB'(opb_s);
    neg  = opa_s[VB-1] ^ opb_s[VB-1] ^ half_q;
  end

  // The |a|*|b| product for variance terms fits in 64 bits: split b in two 32-bit parts,
  // a is at most 24 bits wide in magnitude or n.
  always_comb begin
    mctl = '{start: 1'b0, op: rrrh_pkg::MAC_LOAD};
    ma   = '0;
    mb   = '0;
    msh  = '0;
    case (state_q)
      S_MUL, S_MWAIT: begin
        ma  = absa[31:0];
        mb  = part_q[0] ? absb[63:32] : absb[31:0];
        msh = part_q[0] ? 7'd32 : 7'd0;
        mctl.start = (state_q == S_MWAIT);
        mctl.op    = (part_q == 2'd0) ? rrrh_pkg::MAC_LOAD : rrrh_pkg::MAC_ADD;
      end
      S_PMUL, S_PWAIT: begin
        ma  = part_q[0] ? pa_q[63:32] : pa_q[31:0];
        mb  = part_q[1] ? pb_q[63:32] : pb_q[31:0];
        msh = 7'({5'd0, part_q[0]} + {5'd0, part_q[1]}) << 5;
        mctl.start = (state_q == S_PWAIT);
        mctl.op    = (part_q == 2'd0) ? rrrh_pkg::MAC_LOAD : rrrh_pkg::MAC_ADD;
      end
      default: ;
    endcase
  end

  // Divider step.
  logic [PB+AddrBits-1:0] dsh;
  assign dsh = {{AddrBits{1'b0}}, den_q} << cnt_q[4:0];

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == (AddrBits+1)'(HIST_BINS - 1)) state_d = S_IDLE;
      S_IDLE: if (accept) state_d = (req_type_i == rrrh_pkg::REQ_READ) ? S_RRD : S_ACC;
      S_ACC: if (sub_q == 2'd3 || !take_q) state_d = last_q ? S_MUL : S_IDLE;
      S_MUL: state_d = S_MWAIT;
      S_MWAIT: state_d = (part_q == 2'd1) ? S_VAR : S_MUL;
      S_VAR: state_d = (half_q && term_q == 3'd2) ? S_ABS : S_MUL;
      S_ABS: state_d = (vy_q <= 0) ? S_OUT : ((vx_q <= 0) ? S_RD : S_PMUL);
      S_PMUL: state_d = S_PWAIT;
      S_PWAIT: state_d = (part_q == 2'd3) ? S_PNEXT : S_PMUL;
      S_PNEXT: state_d = pidx_q ? S_NUM : S_PMUL;
      S_NUM: state_d = S_DIV;
      S_DIV: if (cnt_q == 7'd0) state_d = S_RD;
      S_RD: state_d = S_RDW;
      S_RDW: state_d = S_WR;
      S_WR: state_d = S_OUT;
      S_RRD: state_d = S_RRW;
      S_RRW: state_d = S_OUT;
      S_OUT: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  logic signed [VB-1:0] prod_s;
  assign prod_s = neg ? VB'(-$signed(macc[VB-1:0])) : $signed(macc[VB-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      n_q     <= '0;
      sx_q    <= '0;
      sy_q    <= '0;
      sxx_q   <= '0;
      syy_q   <= '0;
      sxy_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) clr_q <= clr_q + 1'b1;
      if (ov_q && out_ready_i) ov_q <= 1'b0;
      if (sub_q == 2'd1) begin
        n_q  <= n_q + 8'd1;
        sx_q <= sx_q + rrrh_pkg::SumXBits'(x_q);
        sy_q <= sy_q + rrrh_pkg::SumXBits'(y_q);
      end
      // Squares and the cross product arrive in turn through sq_q; sub_q tracks which.
      if (sub_q != 2'd0) begin
        case (sub_q)
          2'd1: sxx_q <= sxx_q + rrrh_pkg::SumXXBits'(sq_q);
          2'd2: syy_q <= syy_q + rrrh_pkg::SumXXBits'(sq_q);
          default: sxy_q <= sxy_q + rrrh_pkg::SumXYBits'(sq_q);
        endcase
      end
      if (out_free) begin
        ov_q <= 1'b1;
        if (kind_q == rrrh_pkg::KIND_FIT) begin
          n_q   <= '0;
          sx_q  <= '0;
          sy_q  <= '0;
          sxx_q <= '0;
          syy_q <= '0;
          sxy_q <= '0;
        end
      end
    end
  end

  // Sample products: a multiplier for each of the two squares and the cross product would
  // add units, so they are serialized here one per cycle on one small multiplier.
  logic [1:0] sq_sel_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q    <= 2'd0;
      sq_sel_q <= 2'd0;
    end else begin
      if (accept && req_type_i == rrrh_pkg::REQ_SAMPLE && n_q < 8'(MAX_SAMPLES)) begin
        sq_sel_q <= 2'd1;
      end else if (sq_sel_q != 2'd0) begin
        sq_sel_q <= (sq_sel_q == 2'd3) ? 2'd0 : sq_sel_q + 2'd1;
      end
      sub_q <= sq_sel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (sq_sel_q)
      2'd1:    sq_q <= x_q * x_q;
      2'd2:    sq_q <= y_q * y_q;
      default: sq_q <= x_q * y_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q    <= x_value_i;
      y_q    <= y_value_i;
      last_q <= last_sample_i;
      take_q <= n_q < 8'(MAX_SAMPLES);
      addr_q <= AddrBits'(bin_address_i);
      oor_q  <= 32'(bin_address_i) >= HIST_BINS;
      idx_q  <= bin_address_i;
      kind_q <= req_type_i;
      term_q <= 3'd0;
      half_q <= 1'b0;
      part_q <= 2'd0;
      pidx_q <= 1'b0;
      zv_q   <= 1'b0;
    end
    case (state_q)
      S_MWAIT: part_q <= part_q + 2'd1;
      S_VAR: begin
        part_q <= 2'd0;
        if (!half_q) begin
          t_q <= prod_s;
        end else begin
          case (term_q)
            3'd0:    vx_q <= t_q + prod_s;
            3'd1:    vy_q <= t_q + prod_s;
            default: c_q  <= t_q + prod_s;
          endcase
          term_q <= term_q + 3'd1;
        end
        half_q <= !half_q;
      end
      S_ABS: begin
        part_q <= 2'd0;
        pa_q   <= vx_q;
        pb_q   <= vy_q;
        if (vy_q <= 0) begin
          zv_q  <= 1'b1;
          idx_q <= '0;
          cnt_out_q <= '0;
        end else if (vx_q <= 0) begin
          q_q <= BinMax;
        end
      end
      S_PWAIT: part_q <= part_q + 2'd1;
      S_PNEXT: begin
        if (!pidx_q) begin
          den_q <= macc;
        end
        pa_q   <= c_q[VB-1] ? VB'(-c_q) : VB'(c_q);
        pb_q   <= c_q[VB-1] ? VB'(-c_q) : VB'(c_q);
        pidx_q <= 1'b1;
      end
      S_NUM: begin
        rem_q <= (macc <= den_q) ? ((PB+AddrBits)'(den_q - macc) << AddrBits) : '0;
        q_q   <= '0;
        cnt_q <= 7'(QBits - 1);
      end
      S_DIV: begin
        if (dsh <= rem_q) begin
          rem_q <= rem_q - dsh;
          q_q   <= q_q | (QBits'(1) << cnt_q[4:0]);
        end
        cnt_q <= cnt_q - 7'd1;
      end
      S_RD: if (q_q > BinMax) q_q <= BinMax;
      S_WR: begin
        idx_q     <= 16'(q_q);
        cnt_out_q <= 32'((rd_q < CountMax) ? rd_q + 1'b1 : rd_q);
      end
      S_RRW: cnt_out_q <= oor_q ? 32'd0 : 32'(rd_q);
      default: ;
    endcase
  end

  // Histogram memory: one write port, one registered read port.
  logic [AddrBits-1:0] raddr;
  assign raddr = (state_q == S_RRD) ? addr_q : AddrBits'(q_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      mem[clr_q[AddrBits-1:0]] <= '0;
    end else if (state_q == S_WR) begin
      mem[AddrBits'(q_q)] <= (rd_q < CountMax) ? rd_q + 1'b1 : rd_q;
    end
    rd_q <= mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      res_kind_q <= kind_q;
      res_idx_q  <= idx_q;
      res_cnt_q  <= cnt_out_q;
      res_zv_q   <= zv_q;
    end
  end

  assign out_valid_o     = ov_q;
  assign result_kind_o   = res_kind_q;
  assign bin_index_o     = res_idx_q;
  assign bin_count_o     = res_cnt_q;
  assign zero_variance_o = res_zv_q;

endmodule

@@ rtl/rrrh_checker.sv @@
// Port-level checker for the residual ratio histogram, bound to the top level.
module rrrh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        result_kind_o,
  input logic [15:0] bin_index_o,
  input logic [31:0] bin_count_o,
  input logic        zero_variance_o
);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i) else $error("input item withdrawn");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bin_count_o))
    else $error("result dropped or changed while stalled");

  a_zv_fit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && zero_variance_o |-> result_kind_o == 1'b0 && bin_count_o == 32'd0
    && bin_index_o == 16'd0) else $error("zero variance result malformed");

  a_fit_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o && !zero_variance_o |-> bin_count_o != 32'd0)
    else $error("fit result with zero count");

  a_read_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |-> !zero_variance_o)
    else $error("bin readback flagged as zero variance");

endmodule

bind regression_residual_ratio_histogram rrrh_checker u_rrrh_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_kind_o  (result_kind_o),
  .bin_index_o    (bin_index_o),
  .bin_count_o    (bin_count_o),
  .zero_variance_o(zero_variance_o)
);
